// ===== rtl/core/sara_pkg.sv =====
// ----------------------------------------------------------------------------
// sara_pkg
// Shared types and constants for the slot allocator with reclaim.
// ----------------------------------------------------------------------------
package sara_pkg;

	localparam int CMD_W   = 2;
	localparam int IDX_W   = 6;
	localparam int WIN_W   = 2;
	localparam int OFF_W   = 24;
	localparam int SEQ_W   = 64;
	localparam int S_DATA_W = 8;
	localparam int M_DATA_W = 104;

	typedef logic [CMD_W-1:0] cmd_t;

	localparam cmd_t CMD_ALLOC = 2'd0;
	localparam cmd_t CMD_MARK  = 2'd1;
	localparam cmd_t CMD_FREE  = 2'd2;

	// packed so that ok lands in bit 0
	typedef struct packed {
		logic [SEQ_W-1:0] sequence_count;
		logic [OFF_W-1:0] data_offset;
		logic [WIN_W-1:0] window_index;
		logic             reclaimed;
		logic [IDX_W-1:0] granted_slot;
		logic             ok;
	} res_t;

	localparam int RES_W = $bits(res_t);

endpackage

// ===== rtl/core/sara_ffs.sv =====
// ----------------------------------------------------------------------------
// sara_ffs
// Find-first-set: index of the lowest set bit of a vector.
// ----------------------------------------------------------------------------
module sara_ffs #(
	parameter int WIDTH = 64
) (
	input  logic [WIDTH-1:0]         vec,
	output logic                     found,
	output logic [$clog2(WIDTH)-1:0] index
);

	localparam int IW = $clog2(WIDTH);

	always_comb begin
		index = '0;
		for (int i = WIDTH - 1; i >= 0; i--) begin
			if (vec[i]) begin
				index = IW'(i);
			end
		end
	end

	assign found = |vec;

endmodule

// ===== rtl/core/slot_allocator_with_reclaim_unit.sv =====
// ----------------------------------------------------------------------------
// slot_allocator_with_reclaim_unit
// Lowest-free slot allocator with reclaim of ready slots, ready-sequence
// counter and per-slot window/offset placement.
// ----------------------------------------------------------------------------
// Each transaction is registered in the input stage and again in the result register.
// Throughput: one transaction per cycle unless m_tready stalls the output; an alloc
// is resolved in one pass of the two find-first-set encoders on empty/ready.
// Reset: asynchronous, all slots empty, sequence counter zero, no result held.
// ----------------------------------------------------------------------------
module slot_allocator_with_reclaim_unit
	import sara_pkg::*;
#(
	parameter int NUM_SLOTS     = 64,
	parameter int SLOTS_PER_WIN = 16,
	parameter int SLOT_BYTES    = 1048576,
	parameter int HEADER_BYTES  = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // [5:0] slot_index
	input  logic [CMD_W-1:0]    s_tuser,  // [1:0] command
	output logic                m_tvalid,
	input  logic                m_tready,
	// [0] ok, [6:1] granted_slot, [7] reclaimed, [9:8] window_index,
	// [33:10] data_offset, [97:34] sequence_count
	output logic [M_DATA_W-1:0] m_tdata
);

	localparam int SLOT_W = $clog2(NUM_SLOTS);

	// placement table per slot
	logic [WIN_W-1:0] win_tab [NUM_SLOTS];
	logic [OFF_W-1:0] off_tab [NUM_SLOTS];

	for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_tab
		localparam logic [63:0] WIN = 64'(g / SLOTS_PER_WIN);
		localparam logic [63:0] OFF = 64'(g % SLOTS_PER_WIN) * 64'(SLOT_BYTES)
			+ 64'(HEADER_BYTES);
		assign win_tab[g] = WIN[WIN_W-1:0];
		assign off_tab[g] = OFF[OFF_W-1:0];
	end

	logic                 valid_s1;
	cmd_t                 cmd_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic                 out_valid_q;
	res_t                 res_q;
	logic [NUM_SLOTS-1:0] empty_q;
	logic [NUM_SLOTS-1:0] ready_q;
	logic [SEQ_W-1:0]     seq_q;

	logic                 adv_s1;
	logic                 emp_found;
	logic [SLOT_W-1:0]    emp_idx;
	logic                 rdy_found;
	logic [SLOT_W-1:0]    rdy_idx;
	logic                 in_range;
	logic [SLOT_W-1:0]    idx_slot;
	logic [SLOT_W-1:0]    sel;
	logic                 place;
	logic [NUM_SLOTS-1:0] empty_d;
	logic [NUM_SLOTS-1:0] ready_d;
	logic [SEQ_W-1:0]     seq_d;
	res_t                 res_d;

	assign adv_s1   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	sara_ffs #(.WIDTH(NUM_SLOTS)) u_ffs_empty (
		.vec   (empty_q),
		.found (emp_found),
		.index (emp_idx)
	);

	sara_ffs #(.WIDTH(NUM_SLOTS)) u_ffs_ready (
		.vec   (ready_q),
		.found (rdy_found),
		.index (rdy_idx)
	);

	assign in_range = 32'(idx_s1) < NUM_SLOTS;
	assign idx_slot = SLOT_W'(idx_s1);

	always_comb begin
		empty_d = empty_q;
		ready_d = ready_q;
		seq_d   = seq_q;
		res_d   = '0;
		sel     = '0;
		place   = 1'b0;
		case (cmd_s1)
			CMD_ALLOC: begin
				if (emp_found) begin
					sel   = emp_idx;
					place = 1'b1;
				end else if (rdy_found) begin
					sel             = rdy_idx;
					place           = 1'b1;
					res_d.reclaimed = 1'b1;
				end
				if (place) begin
					empty_d[sel] = 1'b0;
					ready_d[sel] = 1'b0;
				end
			end
			CMD_MARK: begin
				res_d.granted_slot = idx_s1;
				if (in_range) begin
					sel          = idx_slot;
					place        = 1'b1;
					empty_d[sel] = 1'b0;
					ready_d[sel] = 1'b1;
					seq_d        = seq_q + SEQ_W'(1);
				end
			end
			CMD_FREE: begin
				res_d.granted_slot = idx_s1;
				if (in_range) begin
					sel          = idx_slot;
					place        = 1'b1;
					empty_d[sel] = 1'b1;
					ready_d[sel] = 1'b0;
				end
			end
			default: begin
				res_d.granted_slot = idx_s1;
			end
		endcase
		if (place) begin
			res_d.ok           = 1'b1;
			res_d.granted_slot = IDX_W'(sel);
			res_d.window_index = win_tab[sel];
			res_d.data_offset  = off_tab[sel];
		end
		res_d.sequence_count = seq_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			empty_q     <= '1;
			ready_q     <= '0;
			seq_q       <= '0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv_s1) begin
				out_valid_q <= 1'b1;
				empty_q     <= empty_d;
				ready_q     <= ready_d;
				seq_q       <= seq_d;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1 <= s_tuser;
			idx_s1 <= s_tdata[IDX_W-1:0];
		end
		if (adv_s1) begin
			res_q <= res_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(M_DATA_W - RES_W)'(0), res_q};

	a_state_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		(empty_q & ready_q) == '0)
		else $error("slot both empty and ready");

	a_seq_only_on_mark: assert property (@(posedge clk) disable iff (!arst_n)
		!(adv_s1 && cmd_s1 == CMD_MARK) |=> $stable(seq_q))
		else $error("sequence counter moved without a mark");

	a_reclaim_implies_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.reclaimed |-> res_q.ok)
		else $error("reclaim flagged on a failed result");

	a_reclaim_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && emp_found |=> !res_q.reclaimed)
		else $error("reclaim while an empty slot existed");

endmodule
